// ===== rtl/core/ppoc_pkg.sv =====
// Package for the push/pop order checker: command and verdict codes,
// sequencer states and the stream field widths. No dependencies.
package ppoc_pkg;

  localparam int unsigned CmdWidth     = 2;
  localparam int unsigned VerdictWidth = 3;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    VERDICT_NONE   = 3'd0,
    VERDICT_STACK  = 3'd1,
    VERDICT_QUEUE  = 3'd2,
    VERDICT_PRIO   = 3'd3,
    VERDICT_UNSURE = 3'd4
  } verdict_e;

  // Heap sequencer states.
  typedef enum logic [2:0] {
    HS_IDLE,
    HS_UP_RD,
    HS_UP_CMP,
    HS_DN_RD,
    HS_DN_CMP,
    HS_DONE
  } heap_state_e;

  typedef struct packed {
    logic start_push;
    logic start_pop;
  } heap_ctrl_t;

  function automatic verdict_e verdict_of(input logic [2:0] f);
    verdict_e v;
    unique case (f)
      3'b000:  v = VERDICT_NONE;
      3'b001:  v = VERDICT_STACK;
      3'b010:  v = VERDICT_QUEUE;
      3'b100:  v = VERDICT_PRIO;
      default: v = VERDICT_UNSURE;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ppoc_heap.sv =====
// Max-first binary heap with one memory and its compares under a small
// sequencer. Depends on ppoc_pkg.
module ppoc_heap #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned CntWidth    = $clog2(DEPTH + 1),
  parameter int unsigned IdxWidth    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ppoc_pkg::heap_ctrl_t   ctrl_i,
  input  logic                   clear_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic [CntWidth-1:0]    count_o,
  output logic                   done_o,
  output logic                   match_o
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  ppoc_pkg::heap_state_e state_q, state_d;
  logic [CntWidth-1:0]    count_q, count_d;
  logic [IdxWidth-1:0]    idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;     // value being placed
  logic [VALUE_WIDTH-1:0] top_q, top_d;     // removed top on pop
  logic [VALUE_WIDTH-1:0] rd_a_q, rd_b_q;   // registered read data
  logic [VALUE_WIDTH-1:0] ref_q, ref_d;     // value reported by the pop
  logic                   first_q, first_d;
  logic                   match_q, match_d;

  logic [IdxWidth-1:0]    rd_a_addr, rd_b_addr, wr_addr;
  logic                   wr_en;
  logic [VALUE_WIDTH-1:0] wr_data;

  // Child index arithmetic on a width one wider than the count.
  logic [CntWidth:0] child_l, child_r, parent_w;
  assign child_l  = (CntWidth + 1)'({idx_q, 1'b1});
  assign child_r  = child_l + (CntWidth + 1)'(1);
  assign parent_w = ((CntWidth + 1)'(idx_q) - (CntWidth + 1)'(1)) >> 1;

  logic has_l, has_r, pick_r;
  logic [VALUE_WIDTH-1:0] big;
  assign has_l  = child_l < (CntWidth + 1)'(count_q);
  assign has_r  = child_r < (CntWidth + 1)'(count_q);
  assign pick_r = has_r && (rd_b_q > rd_a_q);
  assign big    = pick_r ? rd_b_q : rd_a_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppoc_pkg::HS_IDLE;
      count_q <= '0;
      match_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    val_q   <= val_d;
    top_q   <= top_d;
    ref_q   <= ref_d;
    first_q <= first_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ppoc_pkg::HS_IDLE: begin
        if (ctrl_i.start_push) begin
          state_d = (count_q == '0) ? ppoc_pkg::HS_DONE : ppoc_pkg::HS_UP_RD;
        end else if (ctrl_i.start_pop) begin
          state_d = ppoc_pkg::HS_DN_RD;
        end
      end
      ppoc_pkg::HS_UP_RD:  state_d = ppoc_pkg::HS_UP_CMP;
      ppoc_pkg::HS_UP_CMP: begin
        if (rd_a_q >= val_q || parent_w == '0) state_d = ppoc_pkg::HS_DONE;
        else                                    state_d = ppoc_pkg::HS_UP_RD;
      end
      ppoc_pkg::HS_DN_RD:  state_d = ppoc_pkg::HS_DN_CMP;
      ppoc_pkg::HS_DN_CMP: begin
        if (first_q) state_d = ppoc_pkg::HS_DN_RD;
        else if (!has_l || big <= val_q) state_d = ppoc_pkg::HS_DONE;
        else state_d = ppoc_pkg::HS_DN_RD;
      end
      ppoc_pkg::HS_DONE:   state_d = ppoc_pkg::HS_IDLE;
      default:             state_d = ppoc_pkg::HS_IDLE;
    endcase
    if (clear_i) state_d = ppoc_pkg::HS_IDLE;
  end

  // Datapath and memory control.
  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    val_d     = val_q;
    top_d     = top_q;
    ref_d     = ref_q;
    first_d   = first_q;
    match_d   = match_q;
    rd_a_addr = idx_q;
    rd_b_addr = idx_q;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = val_q;
    unique case (state_q)
      ppoc_pkg::HS_IDLE: begin
        if (ctrl_i.start_push) begin
          idx_d   = IdxWidth'(count_q);
          val_d   = value_i;
          count_d = count_q + CntWidth'(1);
        end else if (ctrl_i.start_pop) begin
          count_d   = count_q - CntWidth'(1);
          idx_d     = '0;
          ref_d     = value_i;
          first_d   = 1'b1;
        end
      end
      ppoc_pkg::HS_UP_RD: begin
        rd_a_addr = IdxWidth'(parent_w);
      end
      ppoc_pkg::HS_UP_CMP: begin
        if (rd_a_q < val_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_q;
          wr_data = rd_a_q;
          idx_d   = IdxWidth'(parent_w);
        end
      end
      ppoc_pkg::HS_DN_RD: begin
        if (first_q) begin
          // First pass reads the root and the last element.
          rd_a_addr = '0;
          rd_b_addr = IdxWidth'(count_q);
        end else begin
          rd_a_addr = IdxWidth'(child_l);
          rd_b_addr = IdxWidth'(child_r);
        end
      end
      ppoc_pkg::HS_DN_CMP: begin
        if (first_q) begin
          top_d   = rd_a_q;
          val_d   = rd_b_q;
          first_d = 1'b0;
        end else if (has_l && big > val_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_q;
          wr_data = big;
          idx_d   = pick_r ? IdxWidth'(child_r) : IdxWidth'(child_l);
        end
      end
      ppoc_pkg::HS_DONE: begin
        wr_en   = (count_q != '0);
        wr_addr = idx_q;
        wr_data = val_q;
        match_d = (top_q == ref_q);
      end
      default: ;
    endcase
    if (clear_i) count_d = '0;
  end

  // The last write of a push also lands in HS_DONE; set top to the pushed
  // value's stand-in there is not needed since match_o is read only on pops.
  assign count_o = count_q;
  assign done_o  = (state_q == ppoc_pkg::HS_DONE);
  assign match_o = match_d;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(DEPTH)) else $error("heap count beyond depth");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ppoc_pkg::HS_DONE |=> state_q == ppoc_pkg::HS_IDLE)
    else $error("heap done not followed by idle");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ppoc_pkg::HS_IDLE |-> !(ctrl_i.start_push || ctrl_i.start_pop))
    else $error("heap started while busy");
`endif

endmodule

// ===== rtl/core/push_pop_order_checker_top.sv =====
// Top level of the push/pop order checker: stream ports, stack and ring
// stores, verdict logic. Depends on ppoc_pkg and ppoc_heap.
//
// Each request is taken whole, then the block is busy until its verdict is
// in the output register. Clear, unused commands, a pop or push that skips
// the heap and a push into an empty heap load their result in the cycle
// after the accepting edge. Any other push or pop waits for the heap sift
// loop, which spends a memory read state and a compare state per level; a
// pop first reads the root and the last element. The stack memory is read
// when the request is accepted, the ring memory at its head every cycle.
// A waiting result holds off the next request until it is taken.
module push_pop_order_checker_top #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] cmd, [VALUE_WIDTH+1:2] value, zero fill to whole bytes
  input  logic [((VALUE_WIDTH+2+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] verdict, [3] overflow, [7:4] zero
  output logic [7:0]                          m_axis_tdata
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam int unsigned IdxWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW       = ppoc_pkg::CmdWidth;

  logic [CW-1:0]          cmd;
  logic [VALUE_WIDTH-1:0] value;
  assign cmd   = s_axis_tdata[CW-1:0];
  assign value = s_axis_tdata[CW+VALUE_WIDTH-1:CW];

  logic [VALUE_WIDTH-1:0] lifo_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] fifo_mem [DEPTH];

  logic                   busy_q, wait_heap_q, out_valid_q;
  logic [ppoc_pkg::VerdictWidth-1:0] verdict_q;
  logic                   ovf_q;
  logic [2:0]             agree_q;
  logic [CntWidth-1:0]    lifo_cnt_q, fifo_cnt_q;
  logic [IdxWidth-1:0]    fifo_head_q;
  logic                   is_pop_q, lifo_ok_q, fifo_ok_q;
  logic [VALUE_WIDTH-1:0] val_q, lifo_rd_q, fifo_rd_q;

  logic                   accept, full_any, lifo_full, fifo_full;
  logic                   heap_done, heap_match;
  logic [CntWidth-1:0]    heap_cnt;
  ppoc_pkg::heap_ctrl_t   hctrl;
  logic                   clear_cmd;
  logic [2:0]             agree_new;

  assign s_axis_tready = !busy_q && !out_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign lifo_full     = lifo_cnt_q == CntWidth'(DEPTH);
  assign fifo_full     = fifo_cnt_q == CntWidth'(DEPTH);
  assign full_any      = lifo_full || fifo_full || heap_cnt == CntWidth'(DEPTH);
  assign clear_cmd     = accept && cmd == ppoc_pkg::CMD_CLEAR;

  assign hctrl.start_push = accept && cmd == ppoc_pkg::CMD_PUSH
                            && heap_cnt != CntWidth'(DEPTH);
  assign hctrl.start_pop  = accept && cmd == ppoc_pkg::CMD_POP && heap_cnt != '0;

  ppoc_heap #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_heap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (hctrl),
    .clear_i (clear_cmd),
    .value_i (value),
    .count_o (heap_cnt),
    .done_o  (heap_done),
    .match_o (heap_match)
  );

  // The ring wraps at DEPTH, which need not be a power of two.
  logic [IdxWidth:0]   tail_sum;
  logic [IdxWidth-1:0] fifo_tail;
  assign tail_sum  = {1'b0, fifo_head_q} + (IdxWidth + 1)'(fifo_cnt_q);
  assign fifo_tail = (tail_sum >= (IdxWidth + 1)'(DEPTH))
                     ? IdxWidth'(tail_sum - (IdxWidth + 1)'(DEPTH))
                     : IdxWidth'(tail_sum);

  always_ff @(posedge clk_i) begin
    if (accept && cmd == ppoc_pkg::CMD_PUSH && !lifo_full)
      lifo_mem[IdxWidth'(lifo_cnt_q)] <= value;
    if (accept && cmd == ppoc_pkg::CMD_PUSH && !fifo_full)
      fifo_mem[fifo_tail] <= value;
    if (accept) lifo_rd_q <= lifo_mem[IdxWidth'(lifo_cnt_q - CntWidth'(1))];
    fifo_rd_q <= fifo_mem[fifo_head_q];
  end

  always_comb begin
    agree_new = agree_q;
    if (is_pop_q) begin
      if (!lifo_ok_q || lifo_rd_q != val_q) agree_new[0] = 1'b0;
      if (!fifo_ok_q || fifo_rd_q != val_q) agree_new[1] = 1'b0;
      if (wait_heap_q ? !heap_match : 1'b1) agree_new[2] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) val_q <= value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      wait_heap_q <= 1'b0;
      out_valid_q <= 1'b0;
      verdict_q   <= ppoc_pkg::VERDICT_UNSURE;
      ovf_q       <= 1'b0;
      agree_q     <= 3'b111;
      lifo_cnt_q  <= '0;
      fifo_cnt_q  <= '0;
      fifo_head_q <= '0;
      is_pop_q    <= 1'b0;
      lifo_ok_q   <= 1'b0;
      fifo_ok_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
      if (accept) begin
        busy_q      <= 1'b1;
        wait_heap_q <= hctrl.start_push || hctrl.start_pop;
        is_pop_q    <= cmd == ppoc_pkg::CMD_POP;
        lifo_ok_q   <= lifo_cnt_q != '0;
        fifo_ok_q   <= fifo_cnt_q != '0;
        unique case (cmd)
          ppoc_pkg::CMD_PUSH: begin
            if (full_any) ovf_q <= 1'b1;
            if (!lifo_full) lifo_cnt_q <= lifo_cnt_q + CntWidth'(1);
            if (!fifo_full) fifo_cnt_q <= fifo_cnt_q + CntWidth'(1);
          end
          ppoc_pkg::CMD_POP: begin
            if (lifo_cnt_q != '0) lifo_cnt_q <= lifo_cnt_q - CntWidth'(1);
            if (fifo_cnt_q != '0) fifo_cnt_q <= fifo_cnt_q - CntWidth'(1);
          end
          ppoc_pkg::CMD_CLEAR: begin
            ovf_q       <= 1'b0;
            agree_q     <= 3'b111;
            lifo_cnt_q  <= '0;
            fifo_cnt_q  <= '0;
            fifo_head_q <= '0;
          end
          default: ;
        endcase
      end else if (busy_q && (!wait_heap_q || heap_done)) begin
        busy_q      <= 1'b0;
        wait_heap_q <= 1'b0;
        out_valid_q <= 1'b1;
        agree_q     <= agree_new;
        verdict_q   <= ppoc_pkg::verdict_of(agree_new);
        if (is_pop_q && fifo_ok_q) begin
          fifo_head_q <= (fifo_head_q == IdxWidth'(DEPTH - 1))
                         ? '0 : fifo_head_q + IdxWidth'(1);
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, ovf_q, verdict_q};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !accept) else $error("request taken while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lifo_cnt_q <= CntWidth'(DEPTH) && fifo_cnt_q <= CntWidth'(DEPTH))
    else $error("store count beyond depth");
  a_counts_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> lifo_cnt_q == fifo_cnt_q) else $error("stack and ring counts differ");
`endif

endmodule

// ===== tb/push_pop_order_checker_top_tb.sv =====
// Self-checking testbench for push_pop_order_checker_top: traces of push, pop,
// clear and unused commands are checked against a stack/queue/heap predictor.
// Depends on ppoc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module push_pop_order_checker_top_tb;

  localparam int unsigned Depth = 64;
  localparam int unsigned ValW  = 16;
  localparam int unsigned DataW = ((ValW + 2 + 7) / 8) * 8;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic               overflow;
    ppoc_pkg::verdict_e verdict;
  } verdict_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;

  push_pop_order_checker_top #(.DEPTH(Depth), .VALUE_WIDTH(ValW)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Predictor state: the three stores and the sticky flags.
  logic [ValW-1:0] lifo_q[$];
  logic [ValW-1:0] fifo_q[$];
  logic [ValW-1:0] heap_q[$];
  logic [2:0]      agree_bits = 3'b111;
  logic            ovf_seen = 1'b0;

  verdict_res_t verdict_q[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic verdict_res_t predict_verdict(ppoc_pkg::cmd_e cmd,
                                                   logic [ValW-1:0] val);
    verdict_res_t r;
    int           top;
    case (cmd)
      ppoc_pkg::CMD_PUSH: begin
        if (lifo_q.size() < Depth) begin
          lifo_q = {lifo_q, val};
          fifo_q = {fifo_q, val};
          heap_q = {heap_q, val};
        end else begin
          ovf_seen = 1'b1;
        end
      end
      ppoc_pkg::CMD_POP: begin
        if (lifo_q.size() == 0) begin
          agree_bits = 3'b000;
        end else begin
          if (lifo_q.pop_back() != val) agree_bits[0] = 1'b0;
          if (fifo_q.pop_front() != val) agree_bits[1] = 1'b0;
          top = 0;
          foreach (heap_q[i]) if (heap_q[i] > heap_q[top]) top = i;
          if (heap_q[top] != val) agree_bits[2] = 1'b0;
          heap_q.delete(top);
        end
      end
      ppoc_pkg::CMD_CLEAR: begin
        lifo_q.delete();
        fifo_q.delete();
        heap_q.delete();
        agree_bits = 3'b111;
        ovf_seen = 1'b0;
      end
      default: ;
    endcase
    if ($countones(agree_bits) == 0) r.verdict = ppoc_pkg::VERDICT_NONE;
    else if ($countones(agree_bits) > 1) r.verdict = ppoc_pkg::VERDICT_UNSURE;
    else if (agree_bits[0]) r.verdict = ppoc_pkg::VERDICT_STACK;
    else if (agree_bits[1]) r.verdict = ppoc_pkg::VERDICT_QUEUE;
    else r.verdict = ppoc_pkg::VERDICT_PRIO;
    r.overflow = ovf_seen;
    return r;
  endfunction

  task automatic send_request(ppoc_pkg::cmd_e cmd, logic [ValW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DataW - ValW - 2){1'b0}}, val, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q = {verdict_q, predict_verdict(cmd, val)};
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // Value that the given discipline would remove next, or a random one.
  function automatic logic [ValW-1:0] next_out(int mode);
    logic [ValW-1:0] m;
    if (lifo_q.size() == 0) return ValW'($urandom);
    case (mode)
      0: return lifo_q[$];
      1: return fifo_q[0];
      default: begin
        m = heap_q[0];
        foreach (heap_q[i]) if (heap_q[i] > m) m = heap_q[i];
        return m;
      end
    endcase
  endfunction

  task automatic test_directed();
    send_request(ppoc_pkg::CMD_POP, 16'h0000);
    send_request(ppoc_pkg::CMD_CLEAR, 16'hffff);
    send_request(ppoc_pkg::CMD_PUSH, 16'h0000);
    send_request(ppoc_pkg::CMD_PUSH, 16'hffff);
    send_request(ppoc_pkg::CMD_PUSH, 16'h8000);
    send_request(ppoc_pkg::CMD_NOP, 16'h1234);
    send_request(ppoc_pkg::CMD_POP, 16'h8000);
    send_request(ppoc_pkg::CMD_POP, 16'hffff);
    send_request(ppoc_pkg::CMD_POP, 16'h0000);
    send_request(ppoc_pkg::CMD_POP, 16'h0000);
    send_request(ppoc_pkg::CMD_NOP, 16'h0000);
    send_request(ppoc_pkg::CMD_CLEAR, 16'h0000);
    send_request(ppoc_pkg::CMD_PUSH, 16'h0005);
    send_request(ppoc_pkg::CMD_PUSH, 16'h0005);
    send_request(ppoc_pkg::CMD_POP, 16'h0005);
    send_request(ppoc_pkg::CMD_POP, 16'h0006);
    send_request(ppoc_pkg::CMD_CLEAR, 16'h0000);
  endtask

  // Fill the stores past full, then drain them in priority order.
  task automatic test_overflow();
    for (int i = 0; i < Depth + 3; i++) send_request(ppoc_pkg::CMD_PUSH, ValW'(i * 977));
    for (int i = 0; i < Depth + 1; i++) send_request(ppoc_pkg::CMD_POP, next_out(2));
    send_request(ppoc_pkg::CMD_CLEAR, 16'h0000);
  endtask

  task automatic test_random(int n_items, int unsigned idle, int unsigned stall);
    int mode;
    int sent;
    int wide;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(2);
      wide = $urandom_range(1);
      send_request(ppoc_pkg::CMD_CLEAR, ValW'($urandom));
      sent++;
      for (int k = 0; k < $urandom_range(40, 4) && sent < n_items; k++) begin
        if ($urandom_range(99) < 4) send_request(ppoc_pkg::CMD_NOP, ValW'($urandom));
        else if ($urandom_range(99) < 50 || lifo_q.size() == 0)
          send_request(ppoc_pkg::CMD_PUSH,
                       wide ? ValW'($urandom) : ValW'($urandom_range(7)));
        else if ($urandom_range(99) < 5)
          send_request(ppoc_pkg::CMD_POP, ValW'($urandom));
        else send_request(ppoc_pkg::CMD_POP, next_out(mode));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    for (int i = 0; i < 8; i++) send_request(ppoc_pkg::CMD_PUSH, ValW'($urandom));
    wait_drained();
    for (int i = 0; i < 8; i++) send_request(ppoc_pkg::CMD_POP, next_out(0));
    wait_drained();
  endtask

  // Receiver side: random stalls plus a counted hold-off on request.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    verdict_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[2:0] !== want.verdict || m_axis_tdata[3] !== want.overflow
            || m_axis_tdata[7:4] !== 4'h0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: verdict exp %0d got %0d, overflow exp %0b got %0b",
                     want.verdict, m_axis_tdata[2:0], want.overflow, m_axis_tdata[3]);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(410, 0, 0);
    test_random(410, 72, 0);
    test_random(410, 0, 72);
    test_random(410, 20, 20);
    test_backpressure();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
